/* sv/vsc_pkg.sv */
`default_nettype none
package vsc_pkg;

  localparam int FracBits = 12;
  localparam int Margin   = 45;
  localparam int PosW     = 16 + FracBits;
  // numerator: pos*ease + tgt<<F * dt, each < 2^(PosW+16)
  localparam int NumW     = PosW + 17;
  localparam int DivW     = 17;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_SCROLL = 2'd1,
    REQ_FIT    = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_EASE  = 3'd0,
    CFG_WW    = 3'd1,
    CFG_WH    = 3'd2,
    CFG_VW    = 3'd3,
    CFG_VH    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        tick_time;
    logic signed [15:0] corner_ax;
    logic signed [15:0] corner_ay;
    logic signed [15:0] corner_bx;
    logic signed [15:0] corner_by;
    logic [2:0]         req_priority;
    logic [23:0]        stay_time;
  } req_word_t;

  typedef struct packed {
    logic [15:0] view_x;
    logic [15:0] view_y;
    logic        redraw;
    logic        accepted;
    logic [15:0] goal_x;
    logic [15:0] goal_y;
    logic [2:0]  held_priority;
  } res_word_t;

endpackage
`default_nettype wire

/* sv/vsc_if.sv */
`default_nettype none
interface vsc_req_if import vsc_pkg::*; ();
  logic      valid;
  logic      ready;
  req_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vsc_res_if import vsc_pkg::*; ();
  logic      valid;
  logic      ready;
  res_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vsc_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

/* sv/vsc_queue.sv */
`default_nettype none
module vsc_queue import vsc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire req_word_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output req_word_t      out_data
);
  // two-entry queue between front and back
  req_word_t  mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      cnt <= cnt + 2'((in_valid && in_ready) ? 1 : 0) - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

/* sv/vsc_divider.sv */
`default_nettype none
module vsc_divider import vsc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DivW-1:0] den,
  output logic                 done,
  output logic [NumW-1:0]      quo
);
  // restoring divider, one quotient bit a cycle
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q;
  logic [DivW:0]   rem;
  logic [DivW-1:0] d;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;

  assign trial = {rem[DivW-1:0], q[NumW-1]};
  assign diff  = trial - {1'b0, d};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        d    <= den;
        rem  <= '0;
        cnt  <= CntW'(NumW);
      end else if (busy) begin
        if (!diff[DivW]) begin
          rem <= diff;
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sv/vsc_back.sv */
`default_nettype none
module vsc_back import vsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire req_word_t   in_data,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_word_t        res_data,
  input  wire logic [15:0] ease_time,
  input  wire logic [15:0] world_width,
  input  wire logic [15:0] world_height,
  input  wire logic [11:0] view_width,
  input  wire logic [11:0] view_height
);
  typedef enum logic [2:0] {
    S_IDLE, S_MULA, S_MULB, S_DIV, S_FINISH, S_OUT
  } state_t;

  localparam logic [PosW-1:0] OnePix  = PosW'(1) << FracBits;
  localparam logic [PosW-1:0] HalfPix = PosW'(1) << (FracBits - 1);

  state_t          state;
  req_word_t       req;
  logic            axis;
  logic [PosW-1:0] pos_x_fix, pos_y_fix;
  logic [15:0]     target_x, target_y;
  logic [2:0]      cur_priority;
  logic [23:0]     stay_left;
  logic [NumW-1:0] num;
  logic            rx;
  logic [15:0]     old_x, old_y;
  logic            reached_x;
  logic            redraw, accepted;

  // shared multiplier operands, one product per cycle
  logic [PosW-1:0] mul_a;
  logic [15:0]     mul_b;
  logic [PosW+15:0] prod;
  logic [PosW-1:0] cur_pos;
  logic [15:0]     cur_tgt;
  logic [PosW-1:0] tfix;
  logic [DivW-1:0] den;
  logic            div_done;
  logic [NumW-1:0] quo;
  logic [PosW-1:0] newpos, adiff;
  logic            reach;

  assign cur_pos = axis ? pos_y_fix : pos_x_fix;
  assign cur_tgt = axis ? target_y : target_x;
  assign tfix    = {cur_tgt, FracBits'(0)};
  assign den     = {1'b0, req.tick_time} + {1'b0, ease_time};
  assign mul_a   = (state == S_MULA) ? cur_pos : tfix;
  assign mul_b   = (state == S_MULA) ? ease_time : req.tick_time;
  assign prod    = mul_a * mul_b;

  vsc_divider u_div (
    .clk(clk), .rst(rst), .start(state == S_MULB && den != '0),
    .num(num + NumW'(prod)), .den(den), .done(div_done), .quo(quo)
  );

  // settle the new position and snap test for the current axis
  always_comb begin
    newpos = (den != '0) ? quo[PosW-1:0] : cur_pos;
    adiff  = (newpos > tfix) ? newpos - tfix : tfix - newpos;
    reach  = adiff < OnePix;
  end

  // make-visible and scroll evaluation
  logic signed [18:0] ipx, ipy, nx, ny, lox, hix, loy, hiy;
  logic               moved;
  logic signed [18:0] px, py, hcx, hcy;
  logic [15:0]        cx, cy;
  logic               do_scroll, take;
  logic [PosW:0]      rnd_x, rnd_y;

  always_comb begin
    ipx = 19'(pos_x_fix[PosW-1:FracBits]);
    ipy = 19'(pos_y_fix[PosW-1:FracBits]);
    // round half up, keeping the carry out of the top pixel
    rnd_x = {1'b0, pos_x_fix} + {1'b0, HalfPix};
    rnd_y = {1'b0, pos_y_fix} + {1'b0, HalfPix};
    nx  = 19'(rnd_x[PosW:FracBits]);
    ny  = 19'(rnd_y[PosW:FracBits]);
    lox = ipx + 19'(Margin);
    hix = ipx + 19'(view_width) - 19'(Margin);
    loy = ipy + 19'(Margin);
    hiy = ipy + 19'(view_height) - 19'(Margin);
    moved = 1'b0;
    if (19'(req.corner_ax) < lox) begin nx = nx - (lox - 19'(req.corner_ax)); moved = 1'b1; end
    if (19'(req.corner_bx) > hix) begin nx = nx + (19'(req.corner_bx) - hix); moved = 1'b1; end
    if (19'(req.corner_ay) < loy) begin ny = ny - (loy - 19'(req.corner_ay)); moved = 1'b1; end
    if (19'(req.corner_by) > hiy) begin ny = ny + (19'(req.corner_by) - hiy); moved = 1'b1; end
    if (req.req_type == REQ_SCROLL) begin
      px = 19'(req.corner_ax);
      py = 19'(req.corner_ay);
      do_scroll = 1'b1;
    end else if (moved) begin
      px = nx;
      py = ny;
      do_scroll = (req.req_type == REQ_FIT);
    end else begin
      px = ipx;
      py = ipy;
      do_scroll = (req.req_type == REQ_FIT) && (req.stay_time != '0);
    end
    hcx = 19'(world_width) - 19'(view_width);
    hcy = 19'(world_height) - 19'(view_height);
    if (px > hcx) px = hcx;
    if (px < 0) px = '0;
    if (py > hcy) py = hcy;
    if (py < 0) py = '0;
    cx = px[15:0];
    cy = py[15:0];
    take = do_scroll && (req.req_priority >= cur_priority);
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_OUT);
  assign res_data  = '{view_x: pos_x_fix[PosW-1:FracBits], view_y: pos_y_fix[PosW-1:FracBits],
                       redraw: redraw, accepted: accepted, goal_x: target_x,
                       goal_y: target_y, held_priority: cur_priority};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos_x_fix    <= '0;
      pos_y_fix    <= '0;
      target_x     <= '0;
      target_y     <= '0;
      cur_priority <= '0;
      stay_left    <= '0;
      redraw       <= 1'b0;
      accepted     <= 1'b0;
      axis         <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req      <= in_data;
            axis     <= 1'b0;
            redraw   <= 1'b0;
            accepted <= 1'b0;
            old_x    <= pos_x_fix[PosW-1:FracBits];
            old_y    <= pos_y_fix[PosW-1:FracBits];
            state    <= (in_data.req_type == REQ_TICK) ? S_MULA : S_FINISH;
          end
        end
        S_MULA: begin
          num   <= NumW'(prod);
          state <= S_MULB;
        end
        S_MULB: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done || den == '0) begin
            if (!axis) begin
              pos_x_fix <= reach ? tfix : newpos;
              reached_x <= reach;
              axis      <= 1'b1;
              state     <= S_MULA;
            end else begin
              pos_y_fix <= reach ? tfix : newpos;
              rx        <= reached_x && reach;
              state     <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (req.req_type == REQ_TICK) begin
            if (rx) begin
              if (stay_left <= 24'(req.tick_time)) begin
                stay_left    <= '0;
                cur_priority <= '0;
              end else begin
                stay_left <= stay_left - 24'(req.tick_time);
              end
            end
            redraw <= (pos_x_fix[PosW-1:FracBits] != old_x) ||
                      (pos_y_fix[PosW-1:FracBits] != old_y);
          end else if (take) begin
            target_x     <= cx;
            target_y     <= cy;
            cur_priority <= req.req_priority;
            stay_left    <= req.stay_time;
            accepted     <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/viewport_scroll_controller_unit.sv */
`default_nettype none
// Viewport scroll controller. Each request word gives one result word. A tick
// runs x, then y, through the multiplier and divider: both axes share one
// multiplier and one restoring divider that yields a quotient bit per cycle.
// Scroll and make-visible requests go from idle to the finish and output
// states. A word enters the two-word queue in front of the executing unit,
// then the unit's request register when it is idle; the queue takes requests
// while a result waits. Write registers only while no request is in flight.
module viewport_scroll_controller_unit import vsc_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  vsc_req_if.sink   req,
  vsc_res_if.source res,
  vsc_cfg_if.sink   cfg
);
  logic [15:0] ease_time, world_width, world_height;
  logic [11:0] view_width, view_height;
  logic        q_valid, q_ready;
  req_word_t   q_data;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ease_time    <= 16'd819;
      world_width  <= '0;
      world_height <= '0;
      view_width   <= 12'd640;
      view_height  <= 12'd480;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_EASE: ease_time    <= cfg.wdata;
        CFG_WW:   world_width  <= cfg.wdata;
        CFG_WH:   world_height <= cfg.wdata;
        CFG_VW:   view_width   <= cfg.wdata[11:0];
        CFG_VH:   view_height  <= cfg.wdata[11:0];
        default: ;
      endcase
    end
  end

  vsc_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  vsc_back u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data),
    .ease_time(ease_time), .world_width(world_width), .world_height(world_height),
    .view_width(view_width), .view_height(view_height)
  );
endmodule
`default_nettype wire
